@@ src/slcfp_pkg.sv @@
// ----------------------------------------------------------------------------
// slcfp_pkg
// Shared types and constants for the sync/length/checksum frame parser.
// ----------------------------------------------------------------------------
package slcfp_pkg;

  // Frame layout
  localparam logic [7:0] SYNC_BYTE       = 8'hF2;
  localparam int         LEN_BIAS        = 4;
  localparam int         TELEMETRY_BYTES = 20;
  localparam int         SEC_PER_MIN     = 60;

  // Telemetry byte positions inside a frame
  localparam int FB_FIRST      = 3;
  localparam int FB_LAST       = 17;
  localparam int IDX_MINUTES   = 3;
  localparam int IDX_SECONDS   = 4;
  localparam int IDX_ENERGY    = 7;
  localparam int IDX_POWER     = 9;
  localparam int IDX_HEART     = 11;
  localparam int IDX_SPEED     = 12;
  localparam int IDX_RESIST    = 15;
  localparam int IDX_CADENCE   = 17;

  // Width of the packed result data word on the output stream
  localparam int RESULT_DATA_W = 104;

  typedef enum logic [1:0] {
    STAT_TELEM    = 2'd0,
    STAT_OTHER    = 2'd1,
    STAT_CSUM_ERR = 2'd2
  } frame_status_t;

  typedef struct packed {
    frame_status_t frame_status;
    logic [6:0]    frame_length;
    logic [7:0]    command_code;
    logic [15:0]   speed_tenths;
    logic [7:0]    cadence_rpm;
    logic [7:0]    resistance_level;
    logic [15:0]   energy_kcal;
    logic [15:0]   power_watts;
    logic [7:0]    heart_rate;
    logic [13:0]   elapsed_seconds;
  } result_t;

endpackage

@@ src/slcfp_parser.sv @@
// ----------------------------------------------------------------------------
// slcfp_parser
// Frame hunt, length check, header rescan, running checksum and telemetry
// decode. One byte is consumed per step; a result is formed in the same cycle.
// ----------------------------------------------------------------------------
module slcfp_parser
  import slcfp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 64,
  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output result_t    res
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] exp_r, exp_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       hw_r   [3];
  logic [7:0]       hw_nxt [3];
  logic [7:0]       fb_r   [FB_FIRST:FB_LAST];

  logic [8:0] len_hdr;
  logic       too_long;
  logic [8:0] len_cur;
  logic [7:0] sum_pre;
  logic       fin;
  logic       sum_ok;
  logic [7:0] b3, b4, b7, b8, b9, b10, b11, b12, b13, b15, b17;

  // Read a telemetry byte; the byte on the input is the one being stored now
  function automatic logic [7:0] tbyte(input int idx, input logic [CNT_W-1:0] cnt,
                                       input logic [7:0] x, input logic [7:0] stored);
    logic hit;
    hit = (int'(cnt) == idx);
    return hit ? x : stored;
  endfunction

  // Header length and checksum terms
  always_comb begin
    len_hdr  = {1'b0, hw_r[2]} + 9'(LEN_BIAS);
    too_long = (int'(len_hdr) > MAX_FRAME_BYTES);
    len_cur  = (int'(cnt_r) == 3) ? len_hdr : 9'(exp_r);
    sum_pre  = (int'(cnt_r) == 3) ? 8'(hw_r[0] + hw_r[1] + hw_r[2]) : sum_r;
    sum_ok   = (sum_pre == rx_byte);
    if (int'(cnt_r) == 3) begin
      fin = !too_long && (int'(len_hdr) == LEN_BIAS);
    end else if (int'(cnt_r) > 3) begin
      fin = ({1'b0, cnt_r} + (CNT_W+1)'(1)) >= {1'b0, exp_r};
    end else begin
      fin = 1'b0;
    end
  end

  // Next state
  always_comb begin
    cnt_nxt = cnt_r;
    exp_nxt = exp_r;
    sum_nxt = sum_r;
    hw_nxt  = hw_r;
    if (step) begin
      if (int'(cnt_r) == 0) begin
        if (rx_byte == SYNC_BYTE) begin
          hw_nxt[0] = rx_byte;
          cnt_nxt   = CNT_W'(1);
        end
      end else if (int'(cnt_r) < 3) begin
        hw_nxt[cnt_r[1:0]] = rx_byte;
        cnt_nxt            = cnt_r + CNT_W'(1);
      end else if (int'(cnt_r) == 3 && too_long) begin
        // drop the sync byte and restart at the next sync in the window
        if (hw_r[1] == SYNC_BYTE) begin
          hw_nxt[0] = hw_r[1];
          hw_nxt[1] = hw_r[2];
          hw_nxt[2] = rx_byte;
          cnt_nxt   = CNT_W'(3);
        end else if (hw_r[2] == SYNC_BYTE) begin
          hw_nxt[0] = hw_r[2];
          hw_nxt[1] = rx_byte;
          cnt_nxt   = CNT_W'(2);
        end else if (rx_byte == SYNC_BYTE) begin
          hw_nxt[0] = rx_byte;
          cnt_nxt   = CNT_W'(1);
        end else begin
          cnt_nxt   = '0;
        end
      end else begin
        if (int'(cnt_r) == 3) begin
          exp_nxt = CNT_W'(len_hdr);
        end
        if (fin) begin
          cnt_nxt = '0;
        end else begin
          sum_nxt = sum_pre + rx_byte;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      exp_r <= '0;
      sum_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      exp_r <= exp_nxt;
      sum_r <= sum_nxt;
    end
  end

  // Header window
  always_ff @(posedge clk) begin
    hw_r <= hw_nxt;
  end

  // Capture telemetry bytes at their fixed positions
  for (genvar i = FB_FIRST; i <= FB_LAST; i++) begin : g_fb
    always_ff @(posedge clk) begin
      if (step && int'(cnt_r) == i) begin
        fb_r[i] <= rx_byte;
      end
    end
  end

  // Telemetry byte view
  always_comb begin
    b3  = tbyte(IDX_MINUTES,    cnt_r, rx_byte, fb_r[IDX_MINUTES]);
    b4  = tbyte(IDX_SECONDS,    cnt_r, rx_byte, fb_r[IDX_SECONDS]);
    b7  = tbyte(IDX_ENERGY,     cnt_r, rx_byte, fb_r[IDX_ENERGY]);
    b8  = tbyte(IDX_ENERGY + 1, cnt_r, rx_byte, fb_r[IDX_ENERGY + 1]);
    b9  = tbyte(IDX_POWER,      cnt_r, rx_byte, fb_r[IDX_POWER]);
    b10 = tbyte(IDX_POWER + 1,  cnt_r, rx_byte, fb_r[IDX_POWER + 1]);
    b11 = tbyte(IDX_HEART,      cnt_r, rx_byte, fb_r[IDX_HEART]);
    b12 = tbyte(IDX_SPEED,      cnt_r, rx_byte, fb_r[IDX_SPEED]);
    b13 = tbyte(IDX_SPEED + 1,  cnt_r, rx_byte, fb_r[IDX_SPEED + 1]);
    b15 = tbyte(IDX_RESIST,     cnt_r, rx_byte, fb_r[IDX_RESIST]);
    b17 = tbyte(IDX_CADENCE,    cnt_r, rx_byte, fb_r[IDX_CADENCE]);
  end

  // Build the result
  always_comb begin
    res              = '0;
    res.frame_length = len_cur[6:0];
    res.command_code = hw_r[1];
    if (!sum_ok) begin
      res.frame_status = STAT_CSUM_ERR;
    end else if (int'(len_cur) == TELEMETRY_BYTES) begin
      res.frame_status     = STAT_TELEM;
      res.speed_tenths     = {b12, b13};
      res.cadence_rpm      = b17;
      res.resistance_level = b15;
      res.energy_kcal      = {b7, b8};
      res.power_watts      = {b9, b10};
      res.heart_rate       = b11;
      res.elapsed_seconds  = 14'(({6'b0, b3} * 14'(SEC_PER_MIN)) + {6'b0, b4});
    end else begin
      res.frame_status = STAT_OTHER;
    end
    res_valid = step && fin;
  end

`ifndef SYNTHESIS
  // The byte count stays inside a legal frame
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) < MAX_FRAME_BYTES)
    else $error("byte count beyond maximum frame length");

  // A result only comes once the header is complete
  a_res_after_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> int'(cnt_r) >= 3)
    else $error("result before header complete");

  // Finishing a frame returns to hunting
  a_fin_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> cnt_r == '0)
    else $error("parser did not return to hunt after a frame");

  // Telemetry status only for a telemetry-length frame
  a_telem_len: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.frame_status == STAT_TELEM) |-> int'(len_cur) == TELEMETRY_BYTES)
    else $error("telemetry status on wrong frame length");
`endif

endmodule

@@ src/slcfp_out_reg.sv @@
// ----------------------------------------------------------------------------
// slcfp_out_reg
// Result register with valid flag; frees itself in the cycle it is taken.
// ----------------------------------------------------------------------------
module slcfp_out_reg
  import slcfp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res_in,
  output logic    ready,
  input  logic    take,
  output logic    valid,
  output result_t res_out
);

  logic    v_r, v_nxt;
  result_t res_r;

  // Space when empty or drained this cycle
  assign ready = !v_r || take;

  always_comb begin
    v_nxt = v_r;
    if (ready) begin
      v_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Hold the payload until taken
  always_ff @(posedge clk) begin
    if (ready && load) begin
      res_r <= res_in;
    end
  end

  assign valid   = v_r;
  assign res_out = res_r;

endmodule

@@ src/sync_length_checksum_frame_parser.sv @@
// ----------------------------------------------------------------------------
// sync_length_checksum_frame_parser
// Serial byte stream frame parser: sync hunt, length check with header
// rescan, additive checksum, telemetry decode.
// ----------------------------------------------------------------------------
// channel | dir | tdata                  | tuser          | tlast
// in_     | in  | rx_byte [7:0]          | -              | -
// out_    | out | frame fields, 104 bits | frame_status   | -
//
// One byte transfer per cycle sustained while the result register has room; a
// result passes the input register and then the result register to the output.
// The result register is the only stall point: while it is full and not
// taken, the input register holds and in_tready drops once it is occupied.
// Reset (rst_n low, synchronous) returns the parser to sync hunt.
// ----------------------------------------------------------------------------
module sync_length_checksum_frame_parser
  import slcfp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,   // [7:0] rx_byte
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [RESULT_DATA_W-1:0] out_tdata,  // frame_length, command_code,
                                               // speed_tenths, cadence_rpm,
                                               // resistance_level, energy_kcal,
                                               // power_watts, heart_rate,
                                               // elapsed_seconds, zero pad
  output logic [1:0]               out_tuser   // [1:0] frame_status
);

  logic       in_v_r, in_v_nxt;
  logic [7:0] in_b_r;
  logic       adv;
  logic       step;
  logic       res_valid;
  result_t    res;
  result_t    res_q;

  // Input register advances when the result side has room
  assign in_tready = !in_v_r || adv;
  assign step      = in_v_r && adv;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_tready) begin
      in_v_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_b_r <= in_tdata;
    end
  end

  slcfp_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .rx_byte  (in_b_r),
    .res_valid(res_valid),
    .res      (res)
  );

  slcfp_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (res_valid),
    .res_in (res),
    .ready  (adv),
    .take   (out_tready),
    .valid  (out_tvalid),
    .res_out(res_q)
  );

  // Pack the result onto the stream
  assign out_tuser = res_q.frame_status;
  assign out_tdata = {3'b000,
                      res_q.elapsed_seconds,
                      res_q.heart_rate,
                      res_q.power_watts,
                      res_q.energy_kcal,
                      res_q.resistance_level,
                      res_q.cadence_rpm,
                      res_q.speed_tenths,
                      res_q.command_code,
                      res_q.frame_length};

endmodule
